[hdl/lipk_pkg.sv]
// Shared types, constants and helpers for the LPC index bitstream packer.
`timescale 1ns / 1ps

package lipk_pkg;

    localparam int MAX_QN     = 36;
    localparam int FIELD_W    = 36;
    localparam int QN_LIMIT   = (MAX_QN > FIELD_W) ? FIELD_W : MAX_QN;
    localparam int QN_W       = 6;
    localparam int LEN_W      = 6;
    localparam int WORD_W     = 16;
    localparam int LIT_W      = 16;
    localparam int SLOTS      = 4;
    localparam int VEC_W      = 3;
    localparam int QDEPTH     = 2;
    localparam int QPTR_W     = $clog2(QDEPTH);
    localparam int QCNT_W     = QPTR_W + 1;
    localparam int FRAMES_W   = 3;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [FRAMES_W-1:0] FRAMES_TWO   = 3'd2;
    localparam logic [FRAMES_W-1:0] FRAMES_FOUR  = 3'd4;
    localparam logic [FRAMES_W-1:0] FRAMES_RESET = FRAMES_FOUR;

    localparam logic REG_FRAMES = 1'b0;

    localparam logic [VEC_W-1:0] VEC_LAST = 3'd7;

    localparam logic [1:0] MODE0 = 2'd0;
    localparam logic [1:0] MODE1 = 2'd1;
    localparam logic [1:0] MODE2 = 2'd2;
    localparam logic [1:0] MODE3 = 2'd3;

    localparam logic [1:0] SPLIT_PLAIN = 2'd0;
    localparam logic [1:0] SPLIT_UNARY = 2'd1;
    localparam logic [1:0] SPLIT_LONG  = 2'd2;
    localparam logic [1:0] SPLIT_MID   = 2'd3;

    typedef enum logic [2:0] {
        SET_ABS,
        SET_FIRST,
        SET_MIDDLE,
        SET_SECOND,
        SET_THIRD
    } set_pos_t;

    typedef enum logic [2:0] {
        FLD_HEAD,
        FLD_ABS,
        FLD_QN0,
        FLD_QN1,
        FLD_BASE,
        FLD_VOR
    } field_pos_t;

    typedef struct packed {
        logic longext;
        logic third;
        logic second;
        logic middle;
        logic first;
    } frame_flags_t;

    typedef struct packed {
        logic [WORD_W-1:0] param_word;
        logic              first_lpd;
        logic [1:0]        mode_first;
        logic [1:0]        mode_third;
    } param_item_t;

    typedef struct packed {
        logic [FIELD_W-1:0] field_value;
        logic [LEN_W-1:0]   field_length;
        logic               last_of_frame;
        logic               qn_clamped;
    } field_item_t;

    typedef struct packed {
        logic             valid;
        logic             unary;
        logic [LEN_W-1:0] len;
        logic [LIT_W-1:0] lit;
        logic             clamped;
    } field_desc_t;

    typedef struct packed {
        field_desc_t [SLOTS-1:0] slot;
        logic                    last;
    } lpc_cmd_t;

    function automatic logic [FIELD_W-1:0] low_mask(input logic [LEN_W-1:0] len);
        logic [FIELD_W:0] m;
        m = ({{FIELD_W{1'b0}}, 1'b1} << len) - {{FIELD_W{1'b0}}, 1'b1};
        return m[FIELD_W-1:0];
    endfunction

endpackage

[hdl/lipk_front.sv]
// Front end: parses parameter words and builds per-item field commands.
`timescale 1ns / 1ps

module lipk_front (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic [lipk_pkg::FRAMES_W-1:0]     frames,
    input  logic                              item_valid,
    input  lipk_pkg::param_item_t             item,
    output logic                              item_stall,
    input  logic                              queue_full,
    output logic                              cmd_valid,
    output lipk_pkg::lpc_cmd_t                cmd
);

    lipk_pkg::set_pos_t     set_reg, set_next;
    lipk_pkg::field_pos_t   fld_reg, fld_next;
    logic [lipk_pkg::VEC_W-1:0] vec_reg, vec_next;
    logic                   half_reg, half_next;
    logic [1:0]             split_reg, split_next;
    logic [lipk_pkg::QN_W-1:0] qn_first_reg, qn_first_next;
    logic [lipk_pkg::QN_W-1:0] qn_second_reg, qn_second_next;
    lipk_pkg::frame_flags_t flags_reg, flags_next;
    logic                   clamp_reg, clamp_next;

    logic                   accept;
    logic [lipk_pkg::WORD_W-1:0] w;
    logic [1:0]             mode;
    logic                   frame_start;
    lipk_pkg::frame_flags_t flags_new;
    lipk_pkg::frame_flags_t flags_eff;
    logic                   written;
    logic                   sat;
    logic [lipk_pkg::QN_W-1:0] qn_in;
    logic [lipk_pkg::QN_W-1:0] qn_cur;
    logic [lipk_pkg::QN_W-1:0] nk_cur;
    logic [lipk_pkg::QN_W-1:0] n_cur;
    logic [lipk_pkg::LEN_W-1:0] base_len;
    logic                   long_rule;
    logic                   clamp_any;
    logic                   finish;
    logic                   cmd_any;
    lipk_pkg::lpc_cmd_t     cmd_c;

    function automatic lipk_pkg::field_desc_t lit_field(
        input logic [lipk_pkg::LEN_W-1:0] len,
        input logic [lipk_pkg::LIT_W-1:0] lit,
        input logic                       clamped
    );
        lipk_pkg::field_desc_t d;
        d.valid   = (len != '0);
        d.unary   = 1'b0;
        d.len     = len;
        d.lit     = lit;
        d.clamped = clamped;
        return d;
    endfunction

    function automatic lipk_pkg::field_desc_t unary_field(
        input logic [lipk_pkg::LEN_W-1:0] len,
        input logic                       clamped
    );
        lipk_pkg::field_desc_t d;
        d.valid   = 1'b1;
        d.unary   = 1'b1;
        d.len     = len;
        d.lit     = '0;
        d.clamped = clamped;
        return d;
    endfunction

    function automatic lipk_pkg::field_desc_t unary_qn(
        input logic [lipk_pkg::QN_W-1:0] qn,
        input logic                      clamped
    );
        logic [lipk_pkg::LEN_W-1:0] len;
        len = (qn > 6'd1) ? lipk_pkg::LEN_W'(qn) : 6'd1;
        return unary_field(len, clamped);
    endfunction

    function automatic lipk_pkg::field_desc_t qn_code(
        input logic [lipk_pkg::QN_W-1:0] qn,
        input logic                      clamped
    );
        logic [1:0] code;
        code = (qn >= 6'd2 && qn <= 6'd5) ? (qn[1:0] - 2'd2) : 2'd3;
        return lit_field(6'd2, {14'b0, code}, clamped);
    endfunction

    function automatic lipk_pkg::field_desc_t qn_ext(
        input logic [lipk_pkg::QN_W-1:0] qn,
        input logic                      long_ext,
        input logic                      clamped
    );
        lipk_pkg::field_desc_t d;
        d = '0;
        if (long_ext)
        begin
            if (qn > 6'd4)
                d = unary_field(lipk_pkg::LEN_W'(qn - 6'd3), clamped);
            else if (qn == 6'd0)
                d = lit_field(6'd1, 16'd0, clamped);
        end
        else
        begin
            priority if (qn == 6'd5)
                d = lit_field(6'd1, 16'd0, clamped);
            else if (qn == 6'd6)
                d = lit_field(6'd2, 16'd2, clamped);
            else if (qn == 6'd0)
                d = lit_field(6'd3, 16'd6, clamped);
            else if (qn > 6'd4)
                d = unary_field(lipk_pkg::LEN_W'(qn - 6'd3), clamped);
            else
                d = '0;
        end
        return d;
    endfunction

    assign accept      = item_valid && !queue_full;
    assign item_stall  = queue_full;
    assign w           = item.param_word;
    assign mode        = w[1:0];
    assign frame_start = (set_reg == lipk_pkg::SET_ABS) && (fld_reg == lipk_pkg::FLD_HEAD);

    always_comb
    begin
        flags_new.first   = item.first_lpd;
        flags_new.middle  = (frames == lipk_pkg::FRAMES_FOUR) && (item.mode_first != lipk_pkg::MODE3);
        flags_new.second  = (item.mode_first == lipk_pkg::MODE0) ||
                            (item.mode_first == lipk_pkg::MODE1);
        flags_new.third   = (frames != lipk_pkg::FRAMES_TWO) &&
                            ((item.mode_third == lipk_pkg::MODE0) ||
                             (item.mode_third == lipk_pkg::MODE1));
        flags_new.longext = (frames != lipk_pkg::FRAMES_TWO);
    end

    assign flags_eff = frame_start ? flags_new : flags_reg;

    always_comb
    begin
        unique case (set_reg)
            lipk_pkg::SET_MIDDLE: written = flags_eff.middle;
            lipk_pkg::SET_SECOND: written = flags_eff.second;
            lipk_pkg::SET_THIRD:  written = flags_eff.third;
            default:              written = 1'b1;
        endcase
    end

    assign sat   = (w > lipk_pkg::WORD_W'(lipk_pkg::QN_LIMIT));
    assign qn_in = sat ? lipk_pkg::QN_W'(lipk_pkg::QN_LIMIT) : w[lipk_pkg::QN_W-1:0];

    assign qn_cur    = half_reg ? qn_second_reg : qn_first_reg;
    assign nk_cur    = (qn_cur > 6'd4) ? ((qn_cur - 6'd3) >> 1) : '0;
    assign n_cur     = qn_cur - {nk_cur[lipk_pkg::QN_W-2:0], 1'b0};
    assign base_len  = {n_cur[3:0], 2'b00};
    assign long_rule = (split_reg == lipk_pkg::SPLIT_LONG) && flags_eff.longext;
    assign clamp_any = clamp_reg | sat;

    always_comb
    begin
        set_next       = set_reg;
        fld_next       = fld_reg;
        vec_next       = vec_reg;
        half_next      = half_reg;
        split_next     = split_reg;
        qn_first_next  = qn_first_reg;
        qn_second_next = qn_second_reg;
        clamp_next     = clamp_reg;
        flags_next     = flags_eff;
        cmd_c          = '0;
        finish         = 1'b0;

        unique case (fld_reg)
            lipk_pkg::FLD_HEAD:
            begin
                if (set_reg == lipk_pkg::SET_ABS)
                begin
                    split_next       = lipk_pkg::SPLIT_PLAIN;
                    cmd_c.slot[0]    = lit_field(6'd8, {8'b0, w[7:0]}, 1'b0);
                    fld_next         = lipk_pkg::FLD_QN0;
                end
                else
                begin
                    if (written)
                    begin
                        unique case (set_reg)
                            lipk_pkg::SET_FIRST, lipk_pkg::SET_MIDDLE:
                            begin
                                cmd_c.slot[0] = lit_field(6'd1, {15'b0, mode[0]}, 1'b0);
                                split_next    = lipk_pkg::SPLIT_MID;
                            end
                            lipk_pkg::SET_SECOND:
                            begin
                                unique case (mode)
                                    lipk_pkg::MODE2:
                                    begin
                                        cmd_c.slot[0] = lit_field(6'd1, 16'd0, 1'b0);
                                        split_next    = lipk_pkg::SPLIT_LONG;
                                    end
                                    lipk_pkg::MODE1:
                                    begin
                                        cmd_c.slot[0] = lit_field(6'd2, 16'd3, 1'b0);
                                        split_next    = lipk_pkg::SPLIT_UNARY;
                                    end
                                    lipk_pkg::MODE0:
                                    begin
                                        cmd_c.slot[0] = lit_field(6'd2, 16'd2, 1'b0);
                                        split_next    = lipk_pkg::SPLIT_PLAIN;
                                    end
                                    default:
                                        split_next    = lipk_pkg::SPLIT_MID;
                                endcase
                            end
                            default:
                            begin
                                unique case (mode)
                                    lipk_pkg::MODE0:
                                    begin
                                        cmd_c.slot[0] = lit_field(6'd2, 16'd2, 1'b0);
                                        split_next    = lipk_pkg::SPLIT_PLAIN;
                                    end
                                    lipk_pkg::MODE1:
                                    begin
                                        cmd_c.slot[0] = lit_field(6'd1, 16'd0, 1'b0);
                                        split_next    = lipk_pkg::SPLIT_UNARY;
                                    end
                                    lipk_pkg::MODE2:
                                    begin
                                        cmd_c.slot[0] = lit_field(6'd3, 16'd6, 1'b0);
                                        split_next    = lipk_pkg::SPLIT_LONG;
                                    end
                                    default:
                                    begin
                                        cmd_c.slot[0] = lit_field(6'd3, 16'd7, 1'b0);
                                        split_next    = lipk_pkg::SPLIT_LONG;
                                    end
                                endcase
                            end
                        endcase
                    end
                    priority if (!written && set_reg != lipk_pkg::SET_SECOND)
                        finish = 1'b1;
                    else if (set_reg == lipk_pkg::SET_SECOND && mode == lipk_pkg::MODE1)
                        finish = 1'b1;
                    else
                        fld_next = (mode == lipk_pkg::MODE0) ? lipk_pkg::FLD_ABS
                                                             : lipk_pkg::FLD_QN0;
                end
            end
            lipk_pkg::FLD_ABS:
            begin
                if (written)
                    cmd_c.slot[0] = lit_field(6'd8, {8'b0, w[7:0]}, 1'b0);
                fld_next = lipk_pkg::FLD_QN0;
            end
            lipk_pkg::FLD_QN0:
            begin
                qn_first_next = qn_in;
                clamp_next    = sat;
                fld_next      = lipk_pkg::FLD_QN1;
            end
            lipk_pkg::FLD_QN1:
            begin
                qn_second_next = qn_in;
                if (written)
                begin
                    if (split_reg == lipk_pkg::SPLIT_UNARY)
                    begin
                        cmd_c.slot[0] = unary_qn(qn_first_reg, clamp_any);
                        cmd_c.slot[1] = unary_qn(qn_in, clamp_any);
                    end
                    else
                    begin
                        cmd_c.slot[0] = qn_code(qn_first_reg, clamp_any);
                        cmd_c.slot[1] = qn_code(qn_in, clamp_any);
                        cmd_c.slot[2] = qn_ext(qn_first_reg, long_rule, clamp_any);
                        cmd_c.slot[3] = qn_ext(qn_in, long_rule, clamp_any);
                    end
                end
                clamp_next = 1'b0;
                vec_next   = '0;
                priority if (qn_first_reg != '0)
                begin
                    half_next = 1'b0;
                    fld_next  = lipk_pkg::FLD_BASE;
                end
                else if (qn_in != '0)
                begin
                    half_next = 1'b1;
                    fld_next  = lipk_pkg::FLD_BASE;
                end
                else
                    finish = 1'b1;
            end
            lipk_pkg::FLD_BASE:
            begin
                if (written)
                    cmd_c.slot[0] = lit_field(base_len, w, 1'b0);
                vec_next = '0;
                fld_next = lipk_pkg::FLD_VOR;
            end
            default:
            begin
                if (written)
                    cmd_c.slot[0] = lit_field(lipk_pkg::LEN_W'(nk_cur), w, 1'b0);
                vec_next = vec_reg + 1'b1;
                if (vec_reg == lipk_pkg::VEC_LAST)
                begin
                    vec_next = '0;
                    if (!half_reg && qn_second_reg != '0)
                    begin
                        half_next = 1'b1;
                        fld_next  = lipk_pkg::FLD_BASE;
                    end
                    else
                        finish = 1'b1;
                end
            end
        endcase

        if (finish)
        begin
            fld_next  = lipk_pkg::FLD_HEAD;
            vec_next  = '0;
            half_next = 1'b0;
            unique case (set_reg)
                lipk_pkg::SET_ABS:
                    set_next = flags_eff.first ? lipk_pkg::SET_FIRST : lipk_pkg::SET_MIDDLE;
                lipk_pkg::SET_FIRST:  set_next = lipk_pkg::SET_MIDDLE;
                lipk_pkg::SET_MIDDLE: set_next = lipk_pkg::SET_SECOND;
                lipk_pkg::SET_SECOND: set_next = lipk_pkg::SET_THIRD;
                default:
                begin
                    set_next   = lipk_pkg::SET_ABS;
                    cmd_c.last = 1'b1;
                end
            endcase
        end

        cmd_any = cmd_c.last;
        for (int i = 0; i < lipk_pkg::SLOTS; i++)
            cmd_any = cmd_any | cmd_c.slot[i].valid;
    end

    assign cmd       = cmd_c;
    assign cmd_valid = accept && cmd_any;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            set_reg       <= lipk_pkg::SET_ABS;
            fld_reg       <= lipk_pkg::FLD_HEAD;
            vec_reg       <= '0;
            half_reg      <= 1'b0;
            split_reg     <= lipk_pkg::SPLIT_PLAIN;
            qn_first_reg  <= '0;
            qn_second_reg <= '0;
            flags_reg     <= '0;
            clamp_reg     <= 1'b0;
        end
        else if (accept)
        begin
            set_reg       <= set_next;
            fld_reg       <= fld_next;
            vec_reg       <= vec_next;
            half_reg      <= half_next;
            split_reg     <= split_next;
            qn_first_reg  <= qn_first_next;
            qn_second_reg <= qn_second_next;
            flags_reg     <= flags_next;
            clamp_reg     <= clamp_next;
        end
    end

endmodule

[hdl/lipk_fifo.sv]
// Command queue between the front end and the field sequencer.
`timescale 1ns / 1ps

module lipk_fifo (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  lipk_pkg::lpc_cmd_t wr_cmd,
    output logic               full,
    input  logic               pop,
    output logic               not_empty,
    output lipk_pkg::lpc_cmd_t rd_cmd
);

    lipk_pkg::lpc_cmd_t             mem [lipk_pkg::QDEPTH];
    logic [lipk_pkg::QPTR_W-1:0]    wr_ptr_reg;
    logic [lipk_pkg::QPTR_W-1:0]    rd_ptr_reg;
    logic [lipk_pkg::QCNT_W-1:0]    count_reg, count_next;

    assign full      = (count_reg == lipk_pkg::QCNT_W'(lipk_pkg::QDEPTH));
    assign not_empty = (count_reg != '0);
    assign rd_cmd    = mem[rd_ptr_reg];

    always_comb
    begin
        unique case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= wr_cmd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            count_reg <= count_next;
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("command pushed into full queue");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> not_empty)
        else $error("command popped from empty queue");
`endif

endmodule

[hdl/lipk_back.sv]
// Field sequencer: expands queued commands into one output field per cycle while the output is not stalled.
`timescale 1ns / 1ps

module lipk_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  head_valid,
    input  lipk_pkg::lpc_cmd_t    head,
    output logic                  pop,
    output logic                  out_valid,
    output lipk_pkg::field_item_t out_item,
    input  logic                  out_stall
);

    logic [lipk_pkg::SLOTS:0] done_reg, done_next;
    logic                     out_valid_reg, out_valid_next;
    lipk_pkg::field_item_t    out_item_reg, out_item_next;

    logic [lipk_pkg::SLOTS:0] all_bits;
    logic [lipk_pkg::SLOTS:0] pending;
    logic [lipk_pkg::SLOTS:0] pick;
    logic [lipk_pkg::SLOTS:0] rest;
    logic                     out_load;
    logic                     advance;
    lipk_pkg::field_desc_t    sel;
    logic [lipk_pkg::FIELD_W-1:0] mask;

    always_comb
    begin
        all_bits[lipk_pkg::SLOTS] = head.last;
        for (int i = 0; i < lipk_pkg::SLOTS; i++)
            all_bits[i] = head.slot[i].valid;
    end

    assign pending  = all_bits & ~done_reg;
    assign pick     = pending & (~pending + 1'b1);
    assign rest     = pending & ~pick;
    assign out_load = !out_valid_reg || !out_stall;
    assign advance  = out_load && head_valid;
    assign pop      = advance && (rest == '0);

    always_comb
    begin
        sel = '0;
        for (int i = 0; i < lipk_pkg::SLOTS; i++)
            if (pick[i])
                sel = head.slot[i];
    end

    assign mask = lipk_pkg::low_mask(sel.len);

    always_comb
    begin
        out_item_next = out_item_reg;
        out_valid_next = out_valid_reg;
        done_next = done_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
            if (pick[lipk_pkg::SLOTS])
            begin
                out_item_next.field_value   = '0;
                out_item_next.field_length  = '0;
                out_item_next.last_of_frame = 1'b1;
                out_item_next.qn_clamped    = 1'b0;
            end
            else
            begin
                out_item_next.field_value   = sel.unary
                    ? (mask & ~{{(lipk_pkg::FIELD_W-1){1'b0}}, 1'b1})
                    : ({{(lipk_pkg::FIELD_W-lipk_pkg::LIT_W){1'b0}}, sel.lit} & mask);
                out_item_next.field_length  = sel.len;
                out_item_next.last_of_frame = 1'b0;
                out_item_next.qn_clamped    = sel.clamped;
            end
            done_next = (rest == '0) ? '0 : (done_reg | pick);
        end
        else if (out_load)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk)
    begin
        out_item_reg <= out_item_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            done_reg      <= '0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            done_reg      <= done_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

`ifndef SYNTHESIS
    a_head_has_work: assert property (@(posedge clk) disable iff (!rst_n)
        head_valid |-> (pending != '0))
        else $error("queued command with no fields left");

    a_zero_len_is_marker: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_item_reg.field_length == '0) |-> out_item_reg.last_of_frame)
        else $error("zero-length field that is not an end marker");

    a_marker_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_item_reg.last_of_frame) |->
            (out_item_reg.field_value == '0 && out_item_reg.field_length == '0 &&
             !out_item_reg.qn_clamped))
        else $error("end marker carries data");

    a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_item_reg.field_length <= lipk_pkg::LEN_W'(lipk_pkg::FIELD_W)))
        else $error("field length beyond field width");
`endif

endmodule

[hdl/lpc_index_bitstream_packer.sv]
// LPC index bitstream packer: top level with config register and submodules.
//
// Usage:
//   param channel: one LPC parameter word per item (param_valid/param_stall,
//   payload param_item). first_lpd, mode_first and mode_third are sampled on
//   the first word of a superframe and ignored otherwise.
//   field channel: one MSB-first bitstream field per item (field_valid/
//   field_stall, payload field_item); a zero-length item with last_of_frame
//   closes the superframe's LPC data.
//   APB register 0 (byte address 0): frames_per_superframe, 2 or 4.
// Timing: an input item is accepted in any cycle the two-entry command queue
//   has room. Its fields pass through the command queue and then the field
//   sequencer's output register. Each word yields zero to five fields; the
//   field sequencer issues one field per cycle while field_stall is low, and a
//   word with no field never enters the queue.
// Reset: parser at the start of the absolute set, frames_per_superframe = 4,
//   queue and output register empty.
// Stall: a stalled field item holds; the queue then fills and param_stall
//   rises until the sequencer drains an entry.
`timescale 1ns / 1ps

module lpc_index_bitstream_packer (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 param_valid,
    output logic                                 param_stall,
    input  lipk_pkg::param_item_t                param_item,
    output logic                                 field_valid,
    input  logic                                 field_stall,
    output lipk_pkg::field_item_t                field_item,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [lipk_pkg::CFG_ADDR_W-1:0]      paddr,
    input  logic [lipk_pkg::CFG_DATA_W-1:0]      pwdata,
    output logic [lipk_pkg::CFG_DATA_W-1:0]      prdata,
    output logic                                 pready
);

    logic [lipk_pkg::FRAMES_W-1:0] frames_reg;
    logic                          cfg_wr;
    logic                          queue_full;
    logic                          queue_not_empty;
    logic                          cmd_valid;
    logic                          pop;
    lipk_pkg::lpc_cmd_t            cmd;
    lipk_pkg::lpc_cmd_t            head;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready &&
                    (paddr[lipk_pkg::CFG_ADDR_W-1] == lipk_pkg::REG_FRAMES);
    assign prdata = (paddr[lipk_pkg::CFG_ADDR_W-1] == lipk_pkg::REG_FRAMES)
                    ? {{(lipk_pkg::CFG_DATA_W-lipk_pkg::FRAMES_W){1'b0}}, frames_reg}
                    : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            frames_reg <= lipk_pkg::FRAMES_RESET;
        else if (cfg_wr)
            frames_reg <= pwdata[lipk_pkg::FRAMES_W-1:0];
    end

    lipk_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .frames     (frames_reg),
        .item_valid (param_valid),
        .item       (param_item),
        .item_stall (param_stall),
        .queue_full (queue_full),
        .cmd_valid  (cmd_valid),
        .cmd        (cmd)
    );

    lipk_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (cmd_valid),
        .wr_cmd    (cmd),
        .full      (queue_full),
        .pop       (pop),
        .not_empty (queue_not_empty),
        .rd_cmd    (head)
    );

    lipk_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (queue_not_empty),
        .head       (head),
        .pop        (pop),
        .out_valid  (field_valid),
        .out_item   (field_item),
        .out_stall  (field_stall)
    );

endmodule
